[rtl/bbhc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbhc_pkg
// shared codes, widths and register indexes of the boiler burner controller
// ----------------------------------------------------------------------------
package bbhc_pkg;

    localparam int TEMP_W  = 16;
    localparam int HYST_W  = 10;
    localparam int MODE_W  = 3;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int POL_W   = 2;
    localparam int IDX_W   = 3;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    // burner commands
    localparam logic [CMD_W-1:0] CMD_HOLD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ON   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_OFF  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SENSOR  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_HARD    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADMODE = 2'd3;

    // run modes
    localparam logic [MODE_W-1:0] MODE_OFF       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COMFORT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ECO       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DHW       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FROSTFREE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TEST      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_AUTO      = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNKNOWN   = 3'd7;

    // idle policies
    localparam logic [POL_W-1:0] POL_NEVER     = 2'd0;
    localparam logic [POL_W-1:0] POL_FROSTFREE = 2'd1;
    localparam logic [POL_W-1:0] POL_SLEEP     = 2'd2;
    // out of range, behaves like sleep
    localparam logic [POL_W-1:0] POL_RESERVED  = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_HYST     = 3'd0;
    localparam logic [IDX_W-1:0] REG_MIN      = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAX      = 3'd2;
    localparam logic [IDX_W-1:0] REG_HARD_MAX = 3'd3;
    localparam logic [IDX_W-1:0] REG_FREEZE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_POLICY   = 3'd5;

    // result word layout
    localparam int M_CMD_LSB     = 0;
    localparam int M_STAT_LSB    = 2;
    localparam int M_TARGET_LSB  = 4;
    localparam int M_PRESENT_BIT = 20;
    localparam int M_AF_BIT      = 21;
    localparam int M_OFFLINE_BIT = 22;

    typedef logic signed [TEMP_W-1:0] temp_t;

endpackage

[rtl/boiler_burner_hysteresis_control.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boiler_burner_hysteresis_control
// hysteresis burner controller with antifreeze latch and idle handling
// ----------------------------------------------------------------------------
// data path: an accepted input word passes the input register, then the result register, to m_
// throughput: one word per cycle while m_tready does not hold the result back, set by the
//   single compare/add pass between the input register and the result register
// reset (aresetn low, synchronous): both stages empty, antifreeze latch and
//   held target cleared, configuration registers back to their defaults
// ----------------------------------------------------------------------------
module boiler_burner_hysteresis_control (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [bbhc_pkg::IDX_W-1:0]     cfg_addr,
    input  logic [bbhc_pkg::TEMP_W-1:0]    cfg_wdata,
    // input samples
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // meas_temp[15:0], sensor_ok[16], mode[19:17], request_temp[35:20],
    // request_valid[36], may_sleep[37], zero[39:38]
    input  logic [bbhc_pkg::S_DATA_W-1:0]  s_tdata,
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // burner_cmd[1:0], status[3:2], target_out[19:4], target_present[20],
    // antifreeze_on[21], went_offline[22], zero[23]
    output logic [bbhc_pkg::M_DATA_W-1:0]  m_tdata
);
    import bbhc_pkg::*;

    // wide enough for every sum and difference of the trip point math
    localparam int W = TEMP_W + 4;

    // configuration registers
    logic [HYST_W-1:0] hyst_reg;
    temp_t             min_reg;
    temp_t             max_reg;
    temp_t             hard_reg;
    temp_t             freeze_reg;
    logic [POL_W-1:0]  policy_reg;

    // controller state
    logic              latch_reg;
    temp_t             hold_reg;
    logic              hold_valid_reg;

    // input register stage
    logic                in_valid_reg;
    logic [S_DATA_W-1:0] in_data_reg;

    // result register stage
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic advance;

    // unpacked input word
    temp_t             bt16;
    logic              sensor_ok;
    logic [MODE_W-1:0] mode;
    temp_t             req16;
    logic              req_valid;
    logic              may_sleep;

    // widened operands
    logic signed [W-1:0] bt, req, tmin, tmax, thard, tfrz, half, hyst;

    // tick logic
    logic                latch_next;
    logic                bad_mode;
    logic                off_mode;
    logic                present;
    logic signed [W-1:0] tgt;
    logic                offline;
    logic signed [W-1:0] trip, untrip, diff, floor_u;
    logic [CMD_W-1:0]    cmd;

    // next state and result
    logic                  latch_upd;
    temp_t                 hold_upd;
    logic                  hold_valid_upd;
    logic [CMD_W-1:0]      res_cmd;
    logic [STAT_W-1:0]     res_stat;
    logic                  res_offline;
    logic [M_DATA_W-1:0]   res_word;

    // result register moves on when empty or taken; input stage follows it
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hyst_reg   <= HYST_W'(60);
            min_reg    <= TEMP_W'(100);
            max_reg    <= TEMP_W'(900);
            hard_reg   <= TEMP_W'(1000);
            freeze_reg <= TEMP_W'(50);
            policy_reg <= POL_NEVER;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HYST:     hyst_reg   <= cfg_wdata[HYST_W-1:0];
                REG_MIN:      min_reg    <= cfg_wdata;
                REG_MAX:      max_reg    <= cfg_wdata;
                REG_HARD_MAX: hard_reg   <= cfg_wdata;
                REG_FREEZE:   freeze_reg <= cfg_wdata;
                REG_POLICY:   policy_reg <= cfg_wdata[POL_W-1:0];
                default: ;    // writes beyond the register list are dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    // ---------------- field unpack ----------------
    assign bt16      = in_data_reg[15:0];
    assign sensor_ok = in_data_reg[16];
    assign mode      = in_data_reg[19:17];
    assign req16     = in_data_reg[35:20];
    assign req_valid = in_data_reg[36];
    assign may_sleep = in_data_reg[37];

    assign bt    = W'(bt16);
    assign req   = W'(req16);
    assign tmin  = W'(min_reg);
    assign tmax  = W'(max_reg);
    assign thard = W'(hard_reg);
    assign tfrz  = W'(freeze_reg);
    // half swing truncates
    assign half  = W'({1'b0, hyst_reg[HYST_W-1:1]});
    assign hyst  = W'({1'b0, hyst_reg});

    // ---------------- tick logic ----------------
    always_comb begin
        // antifreeze: trip at or below freeze point, release above min + half
        latch_next = latch_reg || (bt <= tfrz);
        if (latch_next && (bt > tmin + half)) begin
            latch_next = 1'b0;
        end

        bad_mode = (mode == MODE_AUTO) || (mode == MODE_UNKNOWN);

        // raw target from the run mode
        off_mode = (mode == MODE_OFF);
        tgt      = '0;
        present  = 1'b0;
        if (mode inside {MODE_COMFORT, MODE_ECO, MODE_DHW, MODE_FROSTFREE}) begin
            if (req_valid) begin
                tgt     = req;
                present = 1'b1;
            end
        end else if (mode == MODE_TEST) begin
            tgt     = tmax;
            present = 1'b1;
        end

        // antifreeze raises the target to at least min
        if (latch_next) begin
            if (!present || tgt < tmin) begin
                tgt = tmin;
            end
            present = 1'b1;
        end

        // clamp a present target, else apply the idle policy
        if (present) begin
            if (tgt < tmin) begin
                tgt = tmin;
            end else if (tgt > tmax) begin
                tgt = tmax;
            end
        end else if (policy_reg == POL_NEVER) begin
            tgt     = tmin;
            present = 1'b1;
        end else if (policy_reg == POL_FROSTFREE && mode != MODE_FROSTFREE) begin
            tgt     = tmin;
            present = 1'b1;
        end else if (!may_sleep) begin
            tgt     = tmin;
            present = 1'b1;
        end else begin
            off_mode = 1'b1;    // sleeping counts as mode off
        end

        offline = off_mode && !latch_next;

        // adaptive trip and untrip points
        trip = present ? tgt - half : '0;
        if (present && trip < tmin) begin
            trip = tmin;
        end
        diff    = trip - req;
        floor_u = trip + half;
        if (!req_valid) begin
            untrip = floor_u;
        end else if (diff > 0) begin
            untrip = trip + hyst - diff;
        end else begin
            untrip = trip + hyst;
        end
        if (untrip < floor_u) begin
            untrip = floor_u;
        end
        if (untrip > tmax) begin
            untrip = tmax;
        end

        if (bt < trip) begin
            cmd = CMD_ON;
        end else if (bt > untrip) begin
            cmd = CMD_OFF;
        end else begin
            cmd = CMD_HOLD;
        end
    end

    // ---------------- outcome of the tick ----------------
    always_comb begin
        latch_upd      = latch_reg;
        hold_upd       = hold_reg;
        hold_valid_upd = hold_valid_reg;
        res_cmd        = CMD_HOLD;
        res_stat       = STAT_OK;
        res_offline    = 1'b0;
        if (!sensor_ok) begin
            // sensor fault leaves all state alone
            res_cmd  = CMD_OFF;
            res_stat = STAT_SENSOR;
        end else if (bad_mode) begin
            latch_upd = latch_next;
            res_stat  = STAT_BADMODE;
        end else if (offline) begin
            latch_upd      = 1'b0;
            hold_upd       = '0;
            hold_valid_upd = 1'b0;
            res_cmd        = CMD_OFF;
            res_offline    = 1'b1;
        end else begin
            latch_upd      = latch_next;
            hold_upd       = tgt[TEMP_W-1:0];
            hold_valid_upd = present;
            if (bt > thard) begin
                res_cmd  = CMD_OFF;
                res_stat = STAT_HARD;
            end else begin
                res_cmd = cmd;
            end
        end
        res_word = {1'b0, res_offline, latch_upd, hold_valid_upd, hold_upd,
                    res_stat, res_cmd};
    end

    // ---------------- state and result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg      <= 1'b0;
            hold_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                latch_reg      <= latch_upd;
                hold_reg       <= hold_upd;
                hold_valid_reg <= hold_valid_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_data_reg <= res_word;
        end
    end

endmodule

[rtl/bbhc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbhc_checker
// port-level checks of the burner controller result stream
// ----------------------------------------------------------------------------
module bbhc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bbhc_pkg::M_DATA_W-1:0] m_tdata
);
    import bbhc_pkg::*;

    logic [CMD_W-1:0]  cmd;
    logic [STAT_W-1:0] stat;
    temp_t             target;
    logic              present;
    logic              offline;

    assign cmd     = m_tdata[M_CMD_LSB +: CMD_W];
    assign stat    = m_tdata[M_STAT_LSB +: STAT_W];
    assign target  = m_tdata[M_TARGET_LSB +: TEMP_W];
    assign present = m_tdata[M_PRESENT_BIT];
    assign offline = m_tdata[M_OFFLINE_BIT];

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // every fault or offline word commands the burner off
    a_fault_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (stat == STAT_SENSOR || stat == STAT_HARD || offline)
        |-> cmd == CMD_OFF)
        else $error("fault or offline word without burner off");

    // going offline clears the target and is never a fault
    a_offline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && offline |-> !present && target == '0 && stat == STAT_OK)
        else $error("offline word with target or status set");

    // a missing target is always held as zero
    a_no_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !present |-> target == '0)
        else $error("absent target not zero");

endmodule

bind boiler_burner_hysteresis_control bbhc_checker u_bbhc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/burner_command_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burner_command_checker
// watches the sample and result streams of the burner controller, works out
// the burner command for every accepted sample from its own copy of the
// registers, latch and held target, and compares each result word in order
// ----------------------------------------------------------------------------
module burner_command_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bbhc_pkg::IDX_W-1:0]      cfg_addr,
    input  logic [bbhc_pkg::TEMP_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [bbhc_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bbhc_pkg::M_DATA_W-1:0]   m_tdata,
    output int                              mismatch_count,
    output int                              expected_waiting,
    output int                              results_seen
);
    import bbhc_pkg::*;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [STAT_W-1:0] status;
        temp_t             target;
        logic              present;
        logic              antifreeze;
        logic              offline;
    } burner_result_t;

    // register copy
    logic [HYST_W-1:0] hyst_reg;
    temp_t             min_reg;
    temp_t             max_reg;
    temp_t             hard_reg;
    temp_t             freeze_reg;
    logic [POL_W-1:0]  policy_reg;

    // controller state copy
    logic              frost_latch;
    temp_t             held_target;
    logic              held_valid;

    burner_result_t    pending_results[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      results_seen, name, got, want));
    endtask

    function automatic burner_result_t snapshot(input logic [CMD_W-1:0] cmd,
                                                input logic [STAT_W-1:0] status,
                                                input logic offline);
        burner_result_t res;
        res.cmd        = cmd;
        res.status     = status;
        res.target     = held_target;
        res.present    = held_valid;
        res.antifreeze = frost_latch;
        res.offline    = offline;
        return res;
    endfunction

    function automatic burner_result_t next_burner_result(input logic [S_DATA_W-1:0] word);
        int                btemp, req, half, hyst, tmin, tmax, tgt, trip, untrip, excess;
        logic [MODE_W-1:0] mode;
        logic              req_valid, may_sleep, present, off_mode;
        logic [CMD_W-1:0]  cmd;
        btemp     = int'($signed(word[15:0]));
        mode      = word[19:17];
        req       = int'($signed(word[35:20]));
        req_valid = word[36];
        may_sleep = word[37];
        hyst      = int'(hyst_reg);
        half      = hyst / 2;
        tmin      = int'(min_reg);
        tmax      = int'(max_reg);
        tgt       = 0;
        present   = 1'b0;

        if (!word[16])
            return snapshot(CMD_OFF, STAT_SENSOR, 1'b0);

        if (btemp <= int'(freeze_reg))
            frost_latch = 1'b1;
        if (frost_latch && btemp > tmin + half)
            frost_latch = 1'b0;

        if (mode == MODE_AUTO || mode == MODE_UNKNOWN)
            return snapshot(CMD_HOLD, STAT_BADMODE, 1'b0);

        off_mode = (mode == MODE_OFF);
        if (mode == MODE_TEST) begin
            tgt     = tmax;
            present = 1'b1;
        end else if (mode != MODE_OFF && req_valid) begin
            tgt     = req;
            present = 1'b1;
        end

        // latch forces at least the minimum, a missing request counts as below it
        if (frost_latch) begin
            if (!present || tgt < tmin)
                tgt = tmin;
            present = 1'b1;
        end

        if (present) begin
            if (tgt < tmin)
                tgt = tmin;
            else if (tgt > tmax)
                tgt = tmax;
        end else if (policy_reg == POL_NEVER ||
                     (policy_reg == POL_FROSTFREE && mode != MODE_FROSTFREE) ||
                     !may_sleep) begin
            tgt     = tmin;
            present = 1'b1;
        end else begin
            off_mode = 1'b1;
        end

        held_target = tgt[TEMP_W-1:0];
        held_valid  = present;

        if (off_mode && !frost_latch) begin
            held_target = '0;
            held_valid  = 1'b0;
            return snapshot(CMD_OFF, STAT_OK, 1'b1);
        end

        if (btemp > int'(hard_reg))
            return snapshot(CMD_OFF, STAT_HARD, 1'b0);

        trip = 0;
        if (present) begin
            trip = tgt - half;
            if (trip < tmin)
                trip = tmin;
        end
        untrip = trip + hyst;
        if (req_valid) begin
            excess = trip - req;
            if (excess > 0)
                untrip -= excess;
        end else begin
            untrip = trip + half;
        end
        if (untrip < trip + half)
            untrip = trip + half;
        if (untrip > tmax)
            untrip = tmax;

        if (btemp < trip)
            cmd = CMD_ON;
        else if (btemp > untrip)
            cmd = CMD_OFF;
        else
            cmd = CMD_HOLD;
        return snapshot(cmd, STAT_OK, 1'b0);
    endfunction

    always @(posedge aclk) begin : monitor
        burner_result_t want;
        if (!aresetn) begin
            hyst_reg    = 10'd60;
            min_reg     = 16'sd100;
            max_reg     = 16'sd900;
            hard_reg    = 16'sd1000;
            freeze_reg  = 16'sd50;
            policy_reg  = POL_NEVER;
            frost_latch = 1'b0;
            held_target = '0;
            held_valid  = 1'b0;
            pending_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_HYST:     hyst_reg   = cfg_wdata[HYST_W-1:0];
                    REG_MIN:      min_reg    = cfg_wdata;
                    REG_MAX:      max_reg    = cfg_wdata;
                    REG_HARD_MAX: hard_reg   = cfg_wdata;
                    REG_FREEZE:   freeze_reg = cfg_wdata;
                    REG_POLICY:   policy_reg = cfg_wdata[POL_W-1:0];
                    default: ;
                endcase
            end
            // results first, so a stray word never pairs with a sample taken this edge
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = pending_results.pop_front();
                    compare_field("burner_cmd", m_tdata[M_CMD_LSB +: CMD_W], want.cmd);
                    compare_field("status", m_tdata[M_STAT_LSB +: STAT_W], want.status);
                    compare_field("target_out", $signed(m_tdata[M_TARGET_LSB +: TEMP_W]),
                                  want.target);
                    compare_field("target_present", m_tdata[M_PRESENT_BIT], want.present);
                    compare_field("antifreeze_on", m_tdata[M_AF_BIT], want.antifreeze);
                    compare_field("went_offline", m_tdata[M_OFFLINE_BIT], want.offline);
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(next_burner_result(s_tdata));
        end
        expected_waiting = pending_results.size();
    end

endmodule

[bench/tb_boiler_burner_hysteresis_control.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_boiler_burner_hysteresis_control
// drives temperature samples into the burner controller under changing
// register settings and idle patterns; a checker beside the block predicts
// every result word and this top gives the verdict
// ----------------------------------------------------------------------------
module tb_boiler_burner_hysteresis_control;
    import bbhc_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 7;
    localparam int SEGMENTS         = 9;
    localparam int SEGMENT_ITEMS    = 150;
    localparam int LONG_HOLD_CYCLES = 300;
    // two-stage pipe, spare drain time is plenty before touching registers
    localparam int DRAIN_CYCLES     = 6;
    localparam int CYCLE_LIMIT      = 600000;

    // who idles how often, in percent of cycles
    typedef enum int {IDLE_SLOW_SINK, IDLE_SLOW_SOURCE, IDLE_NONE} idle_mix_e;
    // flavors of register settings
    typedef enum int {CFG_NOMINAL, CFG_WIDE, CFG_SCRAMBLED, CFG_NARROW} cfg_style_e;

    typedef struct {
        int hyst;
        int tmin;
        int tmax;
        int thard;
        int tfreeze;
        int policy;
    } burner_settings_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [IDX_W-1:0]     cfg_addr;
    logic [TEMP_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    // meas_temp[15:0], sensor_ok[16], mode[19:17], request_temp[35:20],
    // request_valid[36], may_sleep[37], zero[39:38]
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // burner_cmd[1:0], status[3:2], target_out[19:4], target_present[20],
    // antifreeze_on[21], went_offline[22], zero[23]
    logic [M_DATA_W-1:0]  m_tdata;

    int               mismatch_count;
    int               expected_waiting;
    int               results_seen;

    // handshake seen at the last rising edge, read back at the falling edge
    logic             s_fire;
    int               send_idle_pct;
    int               recv_idle_pct;
    bit               long_hold_arm;
    bit               long_hold_seen;
    int               samples_sent;
    int               settings_loaded;
    int               cycle_count;
    int               walk_temp;
    burner_settings_t cur_cfg;

    boiler_burner_hysteresis_control DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    burner_command_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatch_count   (mismatch_count),
        .expected_waiting (expected_waiting),
        .results_seen     (results_seen)
    );

    // free-running clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) s_fire <= s_tvalid && s_tready;

    // watchdog: a hung handshake ends the run here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, expected_waiting);
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stalls, plus one long hold-off when armed
    initial begin : result_sink
        int hold_left;
        hold_left      = 0;
        long_hold_seen = 1'b0;
        m_tready       = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (long_hold_arm && !long_hold_seen) begin
                long_hold_seen = 1'b1;
                hold_left      = LONG_HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int clamp16(input int v);
        if (v < -32768)
            return -32768;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    function automatic void set_idle_mix(input idle_mix_e mix);
        case (mix)
            IDLE_SLOW_SINK: begin
                send_idle_pct = 9;
                recv_idle_pct = 84;
            end
            IDLE_SLOW_SOURCE: begin
                send_idle_pct = 84;
                recv_idle_pct = 9;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endfunction

    // one register write per falling edge, enable stays high across the batch
    task automatic put_reg(input logic [IDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[TEMP_W-1:0];
        @(negedge aclk);
    endtask

    // only called with the pipe empty
    task automatic load_settings(input burner_settings_t cfg);
        put_reg(REG_HYST,     cfg.hyst);
        put_reg(REG_MIN,      cfg.tmin);
        put_reg(REG_MAX,      cfg.tmax);
        put_reg(REG_HARD_MAX, cfg.thard);
        put_reg(REG_FREEZE,   cfg.tfreeze);
        put_reg(REG_POLICY,   cfg.policy);
        cfg_wr_en <= 1'b0;
        cur_cfg = cfg;
        settings_loaded++;
        @(negedge aclk);
    endtask

    // stop offering, let every expected word come back, then a spare drain wait
    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        while (expected_waiting != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // offer one sample word and hold it until it is taken
    task automatic send_sample(input int temp, input bit ok, input logic [MODE_W-1:0] mode,
                               input int req, input bit req_valid, input bit may_sleep);
        logic [S_DATA_W-1:0] word;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        word        = '0;
        word[15:0]  = temp[15:0];
        word[16]    = ok;
        word[19:17] = mode;
        word[35:20] = req[15:0];
        word[36]    = req_valid;
        word[37]    = may_sleep;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(negedge aclk); while (!s_fire);
        samples_sent++;
    endtask

    function automatic burner_settings_t pick_settings(input cfg_style_e style);
        burner_settings_t cfg;
        logic [15:0]      raw;
        cfg.hyst   = rand_between(0, 1000);
        cfg.policy = rand_between(0, 2);
        case (style)
            CFG_WIDE: begin
                // widest legal span, largest swing
                cfg.hyst    = 1000;
                cfg.tmin    = -32768;
                cfg.tmax    = 32767;
                cfg.thard   = 32767;
                cfg.tfreeze = -32768;
            end
            CFG_NARROW: begin
                // no swing at all, min and max on top of each other
                cfg.hyst    = 0;
                cfg.tmin    = rand_between(-200, 800);
                cfg.tmax    = cfg.tmin;
                cfg.thard   = cfg.tmax + rand_between(0, 50);
                cfg.tfreeze = cfg.tmin - rand_between(0, 50);
            end
            CFG_SCRAMBLED: begin
                // anything goes, limits in any order
                raw = 16'($urandom);  cfg.tmin    = int'($signed(raw));
                raw = 16'($urandom);  cfg.tmax    = int'($signed(raw));
                raw = 16'($urandom);  cfg.thard   = int'($signed(raw));
                raw = 16'($urandom);  cfg.tfreeze = int'($signed(raw));
                cfg.policy = rand_between(0, 3);
            end
            default: begin
                cfg.tmin    = rand_between(-300, 600);
                cfg.tfreeze = cfg.tmin - rand_between(0, 150);
                cfg.tmax    = cfg.tmin + rand_between(100, 800);
                cfg.thard   = cfg.tmax + rand_between(0, 200);
            end
        endcase
        return cfg;
    endfunction

    // temperatures where the controller changes its mind
    function automatic int pick_threshold();
        case ($urandom_range(5))
            0: return cur_cfg.tfreeze;
            1: return cur_cfg.tmin;
            2: return cur_cfg.tmin + cur_cfg.hyst / 2;
            3: return cur_cfg.tmin + cur_cfg.hyst;
            4: return cur_cfg.tmax;
            default: return cur_cfg.thard;
        endcase
    endfunction

    // mostly a slowly drifting boiler, sometimes a hop onto an edge, sometimes noise
    task automatic send_random_sample();
        int          roll, temp, req, lo, hi;
        logic [15:0] raw;
        logic [MODE_W-1:0] mode;
        roll = $urandom_range(99);
        if (roll < 55) begin
            walk_temp = clamp16(walk_temp + rand_between(-25, 25));
            temp      = walk_temp;
        end else if (roll < 90) begin
            temp = clamp16(pick_threshold() + rand_between(-6, 6));
            if (roll < 65)
                walk_temp = temp;
        end else begin
            raw  = 16'($urandom);
            temp = int'($signed(raw));
        end

        lo   = (cur_cfg.tmin < cur_cfg.tmax) ? cur_cfg.tmin : cur_cfg.tmax;
        hi   = (cur_cfg.tmin < cur_cfg.tmax) ? cur_cfg.tmax : cur_cfg.tmin;
        roll = $urandom_range(99);
        if (roll < 70) begin
            req = clamp16(rand_between(lo - 60, hi + 60));
        end else if (roll < 90) begin
            req = clamp16(temp + rand_between(-80, 80));
        end else begin
            raw = 16'($urandom);
            req = int'($signed(raw));
        end

        mode = ($urandom_range(99) < 90) ? MODE_W'($urandom_range(5))
                                         : MODE_W'($urandom_range(7, 6));
        send_sample(temp, $urandom_range(99) >= 6, mode, req,
                    $urandom_range(99) < 80, 1'($urandom_range(1)));
    endtask

    initial begin : stimulus
        burner_settings_t cfg;
        cfg_style_e       styles[SEGMENTS];
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_addr        = '0;
        cfg_wdata       = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        long_hold_arm   = 1'b0;
        samples_sent    = 0;
        settings_loaded = 0;
        walk_temp       = 400;
        styles = '{CFG_NOMINAL, CFG_WIDE, CFG_NOMINAL, CFG_SCRAMBLED, CFG_NOMINAL,
                   CFG_NARROW, CFG_NOMINAL, CFG_NOMINAL, CFG_SCRAMBLED};
        set_idle_mix(IDLE_SLOW_SINK);

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part on the power-up values, written out explicitly
        cfg = '{hyst: 60, tmin: 100, tmax: 900, thard: 1000, tfreeze: 50, policy: POL_NEVER};
        load_settings(cfg);
        send_sample(500, 1'b0, MODE_COMFORT, 600, 1'b1, 1'b0);      // sensor fault
        send_sample(-32768, 1'b1, MODE_COMFORT, 600, 1'b1, 1'b0);   // coldest, latch sets
        send_sample(120, 1'b1, MODE_COMFORT, 50, 1'b1, 1'b0);       // latched, raised to min
        send_sample(131, 1'b1, MODE_ECO, 32767, 1'b1, 1'b1);        // latch clears, cap at max
        send_sample(32767, 1'b1, MODE_COMFORT, 500, 1'b1, 1'b0);    // over hard limit
        send_sample(400, 1'b1, MODE_AUTO, 500, 1'b1, 1'b0);         // invalid mode
        send_sample(400, 1'b1, MODE_UNKNOWN, 500, 1'b0, 1'b1);      // invalid mode
        send_sample(400, 1'b1, MODE_OFF, 500, 1'b1, 1'b0);          // goes offline
        send_sample(400, 1'b1, MODE_TEST, -32768, 1'b0, 1'b1);      // test runs to max
        send_sample(400, 1'b1, MODE_DHW, -32768, 1'b1, 1'b0);       // request under min
        send_sample(400, 1'b1, MODE_FROSTFREE, 0, 1'b0, 1'b1);      // no request, never idle
        send_sample(700, 1'b1, MODE_COMFORT, 700, 1'b1, 1'b0);      // inside the band
        send_sample(760, 1'b1, MODE_COMFORT, 700, 1'b1, 1'b0);      // above untrip point
        send_sample(30, 1'b1, MODE_OFF, 0, 1'b0, 1'b0);             // off but frost latched
        send_sample(200, 1'b1, MODE_OFF, 0, 1'b0, 1'b0);            // latch drops, offline
        settle_pipeline();

        cfg.policy = POL_FROSTFREE;
        load_settings(cfg);
        send_sample(400, 1'b1, MODE_FROSTFREE, 0, 1'b0, 1'b1);      // frostfree sleeps
        send_sample(400, 1'b1, MODE_ECO, 0, 1'b0, 1'b1);            // other modes stay at min
        settle_pipeline();

        cfg.policy = POL_SLEEP;
        load_settings(cfg);
        send_sample(400, 1'b1, MODE_ECO, 0, 1'b0, 1'b1);            // allowed to sleep
        send_sample(400, 1'b1, MODE_ECO, 0, 1'b0, 1'b0);            // not allowed, min
        settle_pipeline();

        cfg.policy = POL_RESERVED;
        load_settings(cfg);
        send_sample(400, 1'b1, MODE_COMFORT, 0, 1'b0, 1'b1);        // top policy acts as sleep
        send_sample(40, 1'b1, MODE_COMFORT, 0, 1'b0, 1'b1);         // frost overrides sleep
        settle_pipeline();

        // random part: three segments per idle mix, fresh settings per segment
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            set_idle_mix(idle_mix_e'(seg / 3));
            load_settings(pick_settings(styles[seg]));
            walk_temp = clamp16(cur_cfg.tmin + rand_between(-50, 50));
            // back-pressure run: sink holds off while samples keep coming
            if (seg == SEGMENTS - 2)
                long_hold_arm = 1'b1;
            for (int n = 0; n < SEGMENT_ITEMS; n++)
                send_random_sample();
            settle_pipeline();
        end

        $display("sent %0d samples under %0d register settings, %0d results compared",
                 samples_sent, settings_loaded, results_seen);
        $display("idle mixes: slow sink, slow source, none; long sink hold-off %0s",
                 long_hold_seen ? "applied" : "missing");
        if (mismatch_count == 0 && expected_waiting == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     mismatch_count, expected_waiting);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
